@@ hw/rtl/primitive_redex_unit_macros.svh @@
`ifndef PRIMITIVE_REDEX_UNIT_MACROS_SVH
`define PRIMITIVE_REDEX_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PRU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define PRU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ hw/rtl/pru_pkg.sv @@
package pru_pkg;

	localparam logic [3:0] OP_ADD     = 4'd0;
	localparam logic [3:0] OP_SUB     = 4'd1;
	localparam logic [3:0] OP_EQ      = 4'd2;
	localparam logic [3:0] OP_NEQ     = 4'd3;
	localparam logic [3:0] OP_LEQ     = 4'd4;
	localparam logic [3:0] OP_EMIT    = 4'd5;
	localparam logic [3:0] OP_EMITINT = 4'd6;
	localparam logic [3:0] OP_SEQ     = 4'd7;
	localparam logic [3:0] OP_AND     = 4'd8;
	localparam logic [3:0] OP_ST32    = 4'd9;
	localparam logic [3:0] OP_LD32    = 4'd10;

	localparam logic [2:0] TAG_NUM = 3'd0;
	localparam logic [2:0] TAG_CON = 3'd4;

	localparam logic [1:0] ACT_SEQ    = 2'd0;
	localparam logic [1:0] ACT_REDUCE = 2'd1;
	localparam logic [1:0] ACT_SWAP   = 2'd2;

	localparam int LOAD_MISS_VALUE = 666;

	typedef struct packed {
		logic overflow;
		logic emit_valid;
		logic emit_as_int;
		logic store_valid;
		logic load_taken;
		logic halt;
	} flags_t;

endpackage

@@ hw/rtl/pru_req_if.sv @@
interface pru_req_if #(
	parameter int ATOM_WIDTH = 22
);
	logic                         valid;
	logic                         ready;
	logic signed [ATOM_WIDTH-1:0] top_value;
	logic [3:0]                   op_code;
	logic [2:0]                   op_arity;
	logic                         op_swap;
	logic [2:0]                   third_tag;
	logic signed [ATOM_WIDTH-1:0] third_value;
	logic [2:0]                   fourth_tag;
	logic signed [ATOM_WIDTH-1:0] fourth_value;
	logic [7:0]                   load_byte;
	logic                         load_end;

	modport source (
		output valid, top_value, op_code, op_arity, op_swap, third_tag, third_value,
			fourth_tag, fourth_value, load_byte, load_end,
		input ready
	);

	modport sink (
		input valid, top_value, op_code, op_arity, op_swap, third_tag, third_value,
			fourth_tag, fourth_value, load_byte, load_end,
		output ready
	);
endinterface

@@ hw/rtl/pru_rsp_if.sv @@
interface pru_rsp_if #(
	parameter int ATOM_WIDTH = 22
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   action;
	logic [2:0]                   result_tag;
	logic signed [ATOM_WIDTH-1:0] result_value;
	logic [2:0]                   pop_count;
	logic                         overflow;
	logic                         emit_valid;
	logic                         emit_as_int;
	logic signed [ATOM_WIDTH-1:0] emit_value;
	logic                         store_valid;
	logic signed [ATOM_WIDTH-1:0] store_value;
	logic                         load_taken;
	logic                         halt;

	modport source (
		output valid, action, result_tag, result_value, pop_count, overflow, emit_valid,
			emit_as_int, emit_value, store_valid, store_value, load_taken, halt,
		input ready
	);

	modport sink (
		input valid, action, result_tag, result_value, pop_count, overflow, emit_valid,
			emit_as_int, emit_value, store_valid, store_value, load_taken, halt,
		output ready
	);
endinterface

@@ hw/rtl/primitive_redex_unit.sv @@
// Primitive step unit of a graph-reduction core.
// req (sink): one request per primitive step, carrying the numeric stack
//   top, the primitive atom fields, the third and fourth stack atoms and
//   the next serial-in byte with its end flag.
// rsp (source): one result per request, in order: action taken (seq,
//   reduce, swap), atom for the third stack slot, entries to pop, add/sub
//   overflow, emit, store and load side effects, and halt on end of input.
// Timing: a request taken at the handshake lands in the input register,
//   passes one level of ALU logic and moves into the result register
//   when that register is empty or being drained; rsp.valid then rises.
//   Throughput is one request per cycle while rsp.ready stays high; the
//   two registers form a two-deep pipeline.
// Stall: while rsp.ready is low the result holds; the input register can
//   still take one more request, after which req.ready drops until the
//   result is taken.
// Reset: arst_n low empties both registers; rsp.valid drops at once and
//   req.ready is high after release. The unit keeps no other state.
`include "primitive_redex_unit_macros.svh"

module primitive_redex_unit #(
	parameter int ATOM_WIDTH = 22
) (
	input  logic clk,
	input  logic arst_n,
	pru_req_if.sink   req,
	pru_rsp_if.source rsp
);
	import pru_pkg::*;

	logic                         valid_s1;
	logic signed [ATOM_WIDTH-1:0] top_value_s1;
	logic [3:0]                   op_code_s1;
	logic [2:0]                   op_arity_s1;
	logic                         op_swap_s1;
	logic [2:0]                   third_tag_s1;
	logic signed [ATOM_WIDTH-1:0] third_value_s1;
	logic [2:0]                   fourth_tag_s1;
	logic signed [ATOM_WIDTH-1:0] fourth_value_s1;
	logic [7:0]                   load_byte_s1;
	logic                         load_end_s1;

	logic [1:0]                   alu_action;
	logic [2:0]                   alu_tag;
	logic signed [ATOM_WIDTH-1:0] alu_value;
	logic [2:0]                   alu_pop;
	flags_t                       alu_flags;
	logic signed [ATOM_WIDTH-1:0] alu_emit_value;
	logic signed [ATOM_WIDTH-1:0] alu_store_value;

	logic                         valid_s2;
	logic [1:0]                   action_s2;
	logic [2:0]                   tag_s2;
	logic signed [ATOM_WIDTH-1:0] value_s2;
	logic [2:0]                   pop_s2;
	flags_t                       flags_s2;
	logic signed [ATOM_WIDTH-1:0] emit_value_s2;
	logic signed [ATOM_WIDTH-1:0] store_value_s2;

	logic adv_s2;
	logic adv_s1;
	logic take;

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;
	assign take      = req.valid && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			top_value_s1    <= req.top_value;
			op_code_s1      <= req.op_code;
			op_arity_s1     <= req.op_arity;
			op_swap_s1      <= req.op_swap;
			third_tag_s1    <= req.third_tag;
			third_value_s1  <= req.third_value;
			fourth_tag_s1   <= req.fourth_tag;
			fourth_value_s1 <= req.fourth_value;
			load_byte_s1    <= req.load_byte;
			load_end_s1     <= req.load_end;
		end
	end

	pru_alu #(
		.ATOM_WIDTH(ATOM_WIDTH)
	) u_alu (
		.top_value   (top_value_s1),
		.op_code     (op_code_s1),
		.op_arity    (op_arity_s1),
		.op_swap     (op_swap_s1),
		.third_tag   (third_tag_s1),
		.third_value (third_value_s1),
		.fourth_tag  (fourth_tag_s1),
		.fourth_value(fourth_value_s1),
		.load_byte   (load_byte_s1),
		.load_end    (load_end_s1),
		.action      (alu_action),
		.result_tag  (alu_tag),
		.result_value(alu_value),
		.pop_count   (alu_pop),
		.flags       (alu_flags),
		.emit_value  (alu_emit_value),
		.store_value (alu_store_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			action_s2      <= alu_action;
			tag_s2         <= alu_tag;
			value_s2       <= alu_value;
			pop_s2         <= alu_pop;
			flags_s2       <= alu_flags;
			emit_value_s2  <= alu_emit_value;
			store_value_s2 <= alu_store_value;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.action       = action_s2;
	assign rsp.result_tag   = tag_s2;
	assign rsp.result_value = value_s2;
	assign rsp.pop_count    = pop_s2;
	assign rsp.overflow     = flags_s2.overflow;
	assign rsp.emit_valid   = flags_s2.emit_valid;
	assign rsp.emit_as_int  = flags_s2.emit_as_int;
	assign rsp.emit_value   = emit_value_s2;
	assign rsp.store_valid  = flags_s2.store_valid;
	assign rsp.store_value  = store_value_s2;
	assign rsp.load_taken   = flags_s2.load_taken;
	assign rsp.halt         = flags_s2.halt;

	`PRU_ASSERT_NEXT(a_take_fills_s1, take, valid_s1)
	`PRU_ASSERT_NEXT(a_s1_moves_on, valid_s1 && adv_s2, valid_s2)
	`PRU_ASSERT_NOW(a_swap_no_effects, valid_s2 && (action_s2 == ACT_SWAP),
		(pop_s2 == 3'd0) && (flags_s2 == '0))
	`PRU_ASSERT_NOW(a_halt_no_load, valid_s2 && flags_s2.halt,
		!flags_s2.load_taken && (value_s2 == '0) && (action_s2 == ACT_REDUCE))

endmodule

@@ hw/rtl/pru_alu.sv @@
module pru_alu #(
	parameter int ATOM_WIDTH = 22
) (
	input  logic signed [ATOM_WIDTH-1:0] top_value,
	input  logic [3:0]                   op_code,
	input  logic [2:0]                   op_arity,
	input  logic                         op_swap,
	input  logic [2:0]                   third_tag,
	input  logic signed [ATOM_WIDTH-1:0] third_value,
	input  logic [2:0]                   fourth_tag,
	input  logic signed [ATOM_WIDTH-1:0] fourth_value,
	input  logic [7:0]                   load_byte,
	input  logic                         load_end,
	output logic [1:0]                   action,
	output logic [2:0]                   result_tag,
	output logic signed [ATOM_WIDTH-1:0] result_value,
	output logic [2:0]                   pop_count,
	output pru_pkg::flags_t              flags,
	output logic signed [ATOM_WIDTH-1:0] emit_value,
	output logic signed [ATOM_WIDTH-1:0] store_value
);
	import pru_pkg::*;

	logic signed [ATOM_WIDTH-1:0] x;
	logic signed [ATOM_WIDTH-1:0] y;
	logic [2:0]                   y_tag;
	logic [ATOM_WIDTH:0]          sum;
	logic [ATOM_WIDTH:0]          diff;
	logic                         is_emit;
	logic                         x_zero;

	assign x       = op_swap ? third_value : top_value;
	assign y       = op_swap ? top_value : third_value;
	assign y_tag   = op_swap ? TAG_NUM : third_tag;
	assign sum     = {x[ATOM_WIDTH-1], x} + {y[ATOM_WIDTH-1], y};
	assign diff    = {x[ATOM_WIDTH-1], x} - {y[ATOM_WIDTH-1], y};
	assign is_emit = (op_code == OP_EMIT) || (op_code == OP_EMITINT);
	assign x_zero  = (x == '0);

	always_comb begin
		action       = ACT_SWAP;
		result_tag   = TAG_NUM;
		result_value = top_value;
		pop_count    = 3'd0;
		flags        = '0;
		emit_value   = '0;
		store_value  = '0;
		if (op_code == OP_SEQ) begin
			action    = ACT_SEQ;
			pop_count = 3'd1;
		end else if ((third_tag == TAG_NUM) || is_emit) begin
			action       = ACT_REDUCE;
			pop_count    = op_arity;
			result_value = '0;
			case (op_code)
				OP_ADD: begin
					result_value   = sum[ATOM_WIDTH-1:0];
					flags.overflow = sum[ATOM_WIDTH] != sum[ATOM_WIDTH-1];
				end
				OP_SUB: begin
					result_value   = diff[ATOM_WIDTH-1:0];
					flags.overflow = diff[ATOM_WIDTH] != diff[ATOM_WIDTH-1];
				end
				OP_EQ: begin
					result_tag   = TAG_CON;
					result_value = {{(ATOM_WIDTH-1){1'b0}}, x == y};
				end
				OP_NEQ: begin
					result_tag   = TAG_CON;
					result_value = {{(ATOM_WIDTH-1){1'b0}}, x != y};
				end
				OP_LEQ: begin
					result_tag   = TAG_CON;
					result_value = {{(ATOM_WIDTH-1){1'b0}}, x <= y};
				end
				OP_EMIT, OP_EMITINT: begin
					flags.emit_valid  = 1'b1;
					flags.emit_as_int = op_code == OP_EMITINT;
					emit_value        = x;
					result_tag        = y_tag;
					result_value      = y;
				end
				OP_AND: begin
					result_value = x & y;
				end
				OP_ST32: begin
					flags.store_valid = x_zero;
					store_value       = x_zero ? y : '0;
					result_tag        = fourth_tag;
					result_value      = fourth_value;
				end
				OP_LD32: begin
					if (!x_zero) begin
						result_value = ATOM_WIDTH'(LOAD_MISS_VALUE);
					end else if (load_end) begin
						flags.halt = 1'b1;
					end else begin
						flags.load_taken = 1'b1;
						result_value     = {{(ATOM_WIDTH-8){1'b0}}, load_byte};
					end
				end
				default: begin
					result_value = '0;
				end
			endcase
		end
	end

endmodule
